### hw/rtl/kdst_pkg.sv
// kdst_pkg: shared types and constants of the keyed deadline slot table
package kdst_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_TAKE   = 2'd1;
	localparam logic [1:0] KIND_EXPIRE = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] key;
		logic [7:0]  target_x;
		logic [7:0]  target_y;
		logic [30:0] delay;
		logic [31:0] now_time;
	} req_t;

	typedef struct packed {
		logic       success;
		logic [7:0] found_x;
		logic [7:0] found_y;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic has_result;
		logic out_busy;
	} dp_sts_t;

endpackage

### hw/rtl/keyed_deadline_slot_table_core.sv
// keyed_deadline_slot_table_core: top level of the keyed deadline slot table
//
// channel   direction  handshake            payload
// request   in         req_valid/req_stall  req (kdst_pkg::req_t)
// response  out        rsp_valid/rsp_stall  rsp (kdst_pkg::rsp_t)
//
// a request holds the block from start through the scan to finish: one slot per cycle
// through the slot memory read port, plus the registered read and a finish state
// insert and take stop at the first hit, expire always walks the whole table
// reset clears all valid bits at once; slot contents stay undefined until written
// a finished response waits in the output register while rsp_stall is high,
// and the next request is still taken meanwhile
module keyed_deadline_slot_table_core
	import kdst_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	kdst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	kdst_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### hw/rtl/kdst_datapath.sv
// kdst_datapath: slot memory, valid bits, scan counter, compare logic, result and output registers
module kdst_datapath
	import kdst_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output rsp_t    rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef struct packed {
		logic [15:0] key;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [31:0] deadline;
	} slot_t;

	slot_t mem [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [1:0]               kind_q;
	logic [15:0]              key_q;
	logic [7:0]               x_q;
	logic [7:0]               y_q;
	logic [31:0]              deadline_q;
	logic [31:0]              now_q;
	logic [IDX_W-1:0]         cnt_q;
	logic                     issue_done_q;
	slot_t                    rd_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     eval_s1;
	rsp_t                     res_q;
	logic                     out_valid_q;
	rsp_t                     out_q;

	logic eval;
	logic slot_v;
	logic key_hit;
	logic ins_hit;
	logic take_hit;
	logic exp_hit;
	logic has_result;

	assign eval     = cmd.scan && eval_s1;
	assign slot_v   = valid_q[idx_s1];
	assign key_hit  = slot_v && (rd_s1.key == key_q);
	assign ins_hit  = eval && (kind_q == KIND_INSERT) && !slot_v;
	assign take_hit = eval && (kind_q == KIND_TAKE) && key_hit;
	assign exp_hit  = eval && (kind_q == KIND_EXPIRE) && key_hit && (rd_s1.deadline < now_q);

	always_comb begin
		case (kind_q)
			KIND_INSERT, KIND_TAKE: has_result = 1'b1;
			default:                has_result = 1'b0;
		endcase
	end

	assign sts.scan_done  = eval && (ins_hit || take_hit || (idx_s1 == LAST_IDX));
	assign sts.has_result = has_result;
	assign sts.out_busy   = out_valid_q && rsp_stall;

	// request capture, deadline formed once at start
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q     <= req.kind;
			key_q      <= req.key;
			x_q        <= req.target_x;
			y_q        <= req.target_y;
			deadline_q <= req.now_time + {1'b0, req.delay};
			now_q      <= req.now_time;
		end
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (ins_hit) begin
			mem[idx_s1] <= '{key: key_q, x: x_q, y: y_q, deadline: deadline_q};
		end
		if (cmd.scan && !issue_done_q) begin
			rd_s1 <= mem[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && !issue_done_q) begin
			idx_s1 <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			issue_done_q <= 1'b0;
			eval_s1      <= 1'b0;
		end else if (cmd.start) begin
			cnt_q        <= '0;
			issue_done_q <= 1'b0;
			eval_s1      <= 1'b0;
		end else if (cmd.scan) begin
			eval_s1 <= !issue_done_q;
			if (!issue_done_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ins_hit) begin
				valid_q[idx_s1] <= 1'b1;
			end
			if (take_hit || exp_hit) begin
				valid_q[idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_q <= '0;
		end else if (ins_hit) begin
			res_q.success <= 1'b1;
		end else if (take_hit) begin
			res_q <= '{success: 1'b1, found_x: rd_s1.x, found_y: rd_s1.y};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && has_result) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

### hw/rtl/kdst_ctrl.sv
// kdst_ctrl: request sequencing state machine
module kdst_ctrl
	import kdst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   can_finish;

	assign can_finish = !sts.has_result || !sts.out_busy;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (can_finish) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for keyed_deadline_slot_table_core
`timescale 1ns / 1ps

module tb_top;
	import kdst_pkg::*;

	localparam int SLOTS = TABLE_ENTRIES_DEF;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 2000;
	localparam int QUIET_FROM = 5000;
	localparam int QUIET_TO = 8000;
	localparam int HOLD_AT = 12000;
	localparam int HOLD_LEN = 600;
	localparam int STALL_LIMIT = 5000;

	class slot_table_tracker;
		bit          live [SLOTS];
		logic [15:0] owner [SLOTS];
		logic [7:0]  sx [SLOTS];
		logic [7:0]  sy [SLOTS];
		logic [31:0] due [SLOTS];
		rsp_t        pending_rsp [$];
		int errors, accepted, ignored, placed, refused, took, missed, expired, checked;

		function void apply_request(req_t r);
			rsp_t e;
			int hit;
			e = '0;
			hit = -1;
			accepted++;
			case (r.kind)
				KIND_INSERT: begin
					for (int i = 0; i < SLOTS; i++)
						if (!live[i] && hit < 0) hit = i;
					if (hit >= 0) begin
						live[hit] = 1'b1;
						owner[hit] = r.key;
						sx[hit] = r.target_x;
						sy[hit] = r.target_y;
						due[hit] = r.now_time + 32'(r.delay);
						e.success = 1'b1;
						placed++;
					end else begin
						refused++;
					end
					pending_rsp.push_back(e);
				end
				KIND_TAKE: begin
					for (int i = 0; i < SLOTS; i++)
						if (live[i] && owner[i] == r.key && hit < 0) hit = i;
					if (hit >= 0) begin
						live[hit] = 1'b0;
						e.success = 1'b1;
						e.found_x = sx[hit];
						e.found_y = sy[hit];
						took++;
					end else begin
						missed++;
					end
					pending_rsp.push_back(e);
				end
				KIND_EXPIRE: begin
					for (int i = 0; i < SLOTS; i++)
						if (live[i] && owner[i] == r.key && due[i] < r.now_time) begin
							live[i] = 1'b0;
							expired++;
						end
				end
				default: ignored++;
			endcase
		endfunction

		function void match_response(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				$error("response with none expected: success %0d found_x %0d found_y %0d",
					got.success, got.found_x, got.found_y);
				errors++;
				return;
			end
			e = pending_rsp.pop_front();
			checked++;
			if (got.success !== e.success) begin
				$error("success: expected %0d, got %0d", e.success, got.success);
				errors++;
			end
			if (got.found_x !== e.found_x) begin
				$error("found_x: expected %0d, got %0d", e.found_x, got.found_x);
				errors++;
			end
			if (got.found_y !== e.found_y) begin
				$error("found_y: expected %0d, got %0d", e.found_y, got.found_y);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	slot_table_tracker sb = new();
	logic [31:0] tick;
	logic [15:0] key_pool [4];
	int idle_cycles;

	keyed_deadline_slot_table_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side: random stalls, a quiet stretch and one long hold-off
	initial begin
		int cyc;
		cyc = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
				rsp_stall <= 1'b1;
			else if (cyc >= QUIET_FROM && cyc < QUIET_TO)
				rsp_stall <= 1'b0;
			else
				rsp_stall <= ($urandom_range(0, 99) < 10);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) sb.match_response(rsp);
			if (req_valid && !req_stall) sb.apply_request(req);
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_top: no handshake for %0d cycles, %0d responses outstanding",
					STALL_LIMIT, sb.pending_rsp.size());
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	function automatic req_t pack_req(logic [1:0] k, logic [15:0] key, logic [7:0] x,
		logic [7:0] y, logic [30:0] dly, logic [31:0] now);
		req_t r;
		r.kind = k;
		r.key = key;
		r.target_x = x;
		r.target_y = y;
		r.delay = dly;
		r.now_time = now;
		return r;
	endfunction

	function automatic req_t make_request(int ins_w);
		req_t r;
		int p;
		p = $urandom_range(0, 99);
		tick += $urandom_range(0, 50);
		if (p < ins_w) r.kind = KIND_INSERT;
		else if (p < ins_w + 30) r.kind = KIND_TAKE;
		else if (p < 95) r.kind = KIND_EXPIRE;
		else r.kind = KIND_UNUSED;
		if ($urandom_range(0, 99) < 85) r.key = key_pool[$urandom_range(0, 3)];
		else r.key = 16'($urandom());
		r.target_x = 8'($urandom());
		r.target_y = 8'($urandom());
		if ($urandom_range(0, 9) == 0) r.delay = 31'($urandom());
		else r.delay = 31'($urandom_range(0, 400));
		if ($urandom_range(0, 9) == 0) r.now_time = $urandom();
		else r.now_time = tick;
		return r;
	endfunction

	task automatic offer(input req_t r, input int gap);
		if (gap > 0) begin
			@(negedge clk) req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk) begin
			req <= r;
			req_valid <= 1'b1;
		end
		do @(posedge clk); while (req_stall);
	endtask

	initial begin
		req_t r;
		int n, seg, last_seg, ins_w, gap;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		idle_cycles = 0;
		tick = $urandom();
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// empty table, extremes, wrapped deadline, equal deadline, unused kind
		offer(pack_req(KIND_TAKE, 16'h0000, 8'h00, 8'h00, 31'd0, 32'd0), 0);
		offer(pack_req(KIND_INSERT, 16'h0000, 8'h00, 8'h00, 31'd0, 32'd0), 0);
		offer(pack_req(KIND_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 0);
		offer(pack_req(KIND_EXPIRE, 16'hFFFF, 8'h00, 8'h00, 31'd0, 32'h7FFF_FFFF), 0);
		offer(pack_req(KIND_TAKE, 16'hFFFF, 8'h00, 8'h00, 31'd0, 32'd0), 0);
		offer(pack_req(KIND_INSERT, 16'h1234, 8'h5A, 8'hA5, 31'd100, 32'd1000), 0);
		offer(pack_req(KIND_EXPIRE, 16'h1234, 8'h00, 8'h00, 31'd0, 32'd1100), 0);
		offer(pack_req(KIND_TAKE, 16'h1234, 8'h00, 8'h00, 31'd0, 32'd0), 0);
		offer(pack_req(KIND_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 0);
		// fill the table, then insert into a full table
		for (int i = 0; i < SLOTS - 1; i++)
			offer(pack_req(KIND_INSERT, 16'h5A5A ^ 16'(i * 16'h0101), 8'(i), 8'(8'hFF - i),
				31'(i * 3), 32'h8000_0000), 0);
		offer(pack_req(KIND_INSERT, 16'hAAAA, 8'h55, 8'hAA, 31'd1, 32'd1), 0);
		offer(pack_req(KIND_TAKE, 16'h0000, 8'h00, 8'h00, 31'd0, 32'd0), 0);

		n = 0;
		last_seg = -1;
		ins_w = 40;
		while (n < RANDOM_REQUESTS) begin
			seg = n / 250;
			if (seg != last_seg) begin
				last_seg = seg;
				ins_w = $urandom_range(25, 55);
				foreach (key_pool[k]) key_pool[k] = 16'($urandom());
			end
			r = make_request(ins_w);
			if (n >= 600 && n < 1000) gap = 0;
			else if ($urandom_range(0, 99) < 30) gap = $urandom_range(1, 6);
			else gap = 0;
			offer(r, gap);
			if (r.kind != KIND_UNUSED) n++;
		end
		@(negedge clk) req_valid <= 1'b0;

		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		$display("tb_top: %0d requests (%0d unused kind); %0d inserts placed, %0d refused as full",
			sb.accepted, sb.ignored, sb.placed, sb.refused);
		$display("tb_top: takes found %0d, missed %0d; slots expired %0d; responses checked %0d",
			sb.took, sb.missed, sb.expired, sb.checked);
		if (sb.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
